>>> sv/gic_pkg.sv
package gic_pkg;

    localparam int unsigned BUTTONS_W   = 32;
    localparam int unsigned STICK_W     = 8;
    localparam int unsigned ELAPSED_W   = 24;
    localparam int unsigned DEADZONE_W  = 7;
    localparam int unsigned DELAY_W     = 24;
    localparam int unsigned RATE_W      = 24;
    localparam int unsigned DZ_SQ_W     = 2 * DEADZONE_W;
    localparam int unsigned NUM_DIRS    = 4;

    localparam int unsigned S_TDATA_W   = 104;
    localparam int unsigned M_TDATA_W   = 120;

    localparam int unsigned CFG_ADDR_W  = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam int unsigned TIMER_BITS_DEF = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_DEADZONE     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_DELAY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_RATE  = 2'd2;

    localparam logic [DEADZONE_W-1:0] DEADZONE_RST     = 7'd48;
    localparam logic [DELAY_W-1:0]    REPEAT_DELAY_RST = 24'd400000;
    localparam logic [RATE_W-1:0]     REPEAT_RATE_RST  = 24'd100000;
    localparam logic [DZ_SQ_W-1:0]    DZ_SQ_RST        = 14'd2304;

    // d-pad bit positions in the button mask
    localparam int unsigned DIR_UP_BIT    = 4;
    localparam int unsigned DIR_RIGHT_BIT = 5;
    localparam int unsigned DIR_DOWN_BIT  = 6;
    localparam int unsigned DIR_LEFT_BIT  = 7;

    // repeat lane order: up, down, left, right
    localparam int unsigned DIR_LANE_POS [NUM_DIRS] = '{
        DIR_UP_BIT, DIR_DOWN_BIT, DIR_LEFT_BIT, DIR_RIGHT_BIT
    };

endpackage

>>> sv/gamepad_input_conditioner_core.sv
// Gamepad input conditioner: stick folding into d-pad bits, radial deadzone,
// press/release edges and per-direction auto-repeat.
// Input channel s_*: one poll item per handshake (tvalid & tready).
// Result channel m_*: one result item per poll item, in order.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata, 0 deadzone, 1 repeat delay,
// 2 repeat rate; other indexes are ignored. Write only while the block is idle.
// Path: an accepted item goes via the input register to the result register.
// Throughput: one item per cycle unless m_* stalls; the input register feeds
// one combinational stage (two 8x8 squares and a compare, four timer
// add/saturate/subtract lanes) into the result register; the carried state
// (previous mask and timers) updates at the same edge as the result register.
// Reset (aresetn low, synchronous): registers return to their defaults, the
// previous mask and all timers clear, both valid flags drop.
// When the receiver stalls, the result is held, the input register keeps one
// more item, and s_tready drops until the result is taken.
module gamepad_input_conditioner_core #(
    parameter int unsigned TIMER_BITS = gic_pkg::TIMER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // buttons, sim_buttons, stick_x, stick_y, elapsed_us
    input  logic [gic_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // held_mask, pressed_mask, released_mask, repeat_dirs, axis_x, axis_y, pad
    output logic [gic_pkg::M_TDATA_W-1:0]       m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [gic_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [gic_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import gic_pkg::*;

    localparam int unsigned SUM_W = ((TIMER_BITS > ELAPSED_W) ? TIMER_BITS : ELAPSED_W) + 1;

    logic [DEADZONE_W-1:0] deadzone_reg;
    logic [DELAY_W-1:0]    delay_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [DZ_SQ_W-1:0]    dz_sq_reg;

    logic                  in_valid_reg;
    logic [BUTTONS_W-1:0]  in_buttons_reg;
    logic [BUTTONS_W-1:0]  in_sim_reg;
    logic [STICK_W-1:0]    in_stick_x_reg;
    logic [STICK_W-1:0]    in_stick_y_reg;
    logic [ELAPSED_W-1:0]  in_elapsed_reg;

    logic                  m_valid_reg;
    logic [BUTTONS_W-1:0]  held_reg;
    logic [BUTTONS_W-1:0]  pressed_reg;
    logic [BUTTONS_W-1:0]  released_reg;
    logic [NUM_DIRS-1:0]   repeat_reg;
    logic [STICK_W-1:0]    axis_x_reg;
    logic [STICK_W-1:0]    axis_y_reg;

    logic [BUTTONS_W-1:0]  prev_mask_reg;
    logic [TIMER_BITS-1:0] timer_reg [NUM_DIRS];

    logic                  advance;
    logic                  s_fire;

    logic [BUTTONS_W-1:0]  held_next;
    logic [BUTTONS_W-1:0]  pressed_next;
    logic [BUTTONS_W-1:0]  released_next;
    logic [NUM_DIRS-1:0]   repeat_next;
    logic [STICK_W-1:0]    axis_x_next;
    logic [STICK_W-1:0]    axis_y_next;
    logic [TIMER_BITS-1:0] timer_next [NUM_DIRS];

    logic signed [STICK_W-1:0]   ax;
    logic signed [STICK_W-1:0]   ay;
    logic signed [STICK_W:0]     ax9;
    logic signed [STICK_W:0]     ay9;
    logic signed [STICK_W:0]     dz9;
    logic signed [2*STICK_W-1:0] ax_sq;
    logic signed [2*STICK_W-1:0] ay_sq;
    logic [2*STICK_W:0]          mag_sq;
    logic                        in_radial;

    logic [SUM_W-1:0] tsum [NUM_DIRS];
    logic [SUM_W-1:0] tsat [NUM_DIRS];
    logic [SUM_W-1:0] tmax;
    logic [SUM_W-1:0] delay_ext;
    logic [SUM_W-1:0] rate_ext;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DEADZONE_RST;
            delay_reg    <= REPEAT_DELAY_RST;
            rate_reg     <= REPEAT_RATE_RST;
            dz_sq_reg    <= DZ_SQ_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DEADZONE: begin
                    deadzone_reg <= cfg_wdata[DEADZONE_W-1:0];
                    dz_sq_reg    <= DZ_SQ_W'(cfg_wdata[DEADZONE_W-1:0])
                                  * DZ_SQ_W'(cfg_wdata[DEADZONE_W-1:0]);
                end
                REG_REPEAT_DELAY: delay_reg <= cfg_wdata[DELAY_W-1:0];
                REG_REPEAT_RATE:  rate_reg  <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_buttons_reg <= s_tdata[31:0];
            in_sim_reg     <= s_tdata[63:32];
            in_stick_x_reg <= s_tdata[71:64];
            in_stick_y_reg <= s_tdata[79:72];
            in_elapsed_reg <= s_tdata[103:80];
        end
    end

    // stick centering, folding and radial deadzone
    always_comb begin
        ax  = signed'({~in_stick_x_reg[STICK_W-1], in_stick_x_reg[STICK_W-2:0]});
        ay  = signed'({~in_stick_y_reg[STICK_W-1], in_stick_y_reg[STICK_W-2:0]});
        ax9 = (STICK_W+1)'(ax);
        ay9 = (STICK_W+1)'(ay);
        dz9 = signed'({2'b00, deadzone_reg});

        held_next = in_buttons_reg | in_sim_reg;
        if (ax9 < -dz9) held_next[DIR_LEFT_BIT]  = 1'b1;
        if (ax9 > dz9)  held_next[DIR_RIGHT_BIT] = 1'b1;
        if (ay9 < -dz9) held_next[DIR_UP_BIT]    = 1'b1;
        if (ay9 > dz9)  held_next[DIR_DOWN_BIT]  = 1'b1;

        ax_sq     = ax * ax;
        ay_sq     = ay * ay;
        mag_sq    = (2*STICK_W+1)'(unsigned'(ax_sq)) + (2*STICK_W+1)'(unsigned'(ay_sq));
        in_radial = mag_sq < (2*STICK_W+1)'(dz_sq_reg);

        axis_x_next = in_radial ? '0 : unsigned'(ax);
        axis_y_next = in_radial ? '0 : unsigned'(ay);

        pressed_next  = held_next & ~prev_mask_reg;
        released_next = prev_mask_reg & ~held_next;
    end

    // auto-repeat timer lanes
    always_comb begin
        tmax      = SUM_W'({TIMER_BITS{1'b1}});
        delay_ext = SUM_W'(delay_reg);
        rate_ext  = SUM_W'(rate_reg);
        for (int i = 0; i < NUM_DIRS; i++) begin
            tsum[i]        = SUM_W'(timer_reg[i]) + SUM_W'(in_elapsed_reg);
            tsat[i]        = (tsum[i] > tmax) ? tmax : tsum[i];
            repeat_next[i] = 1'b0;
            timer_next[i]  = '0;
            if (held_next[DIR_LANE_POS[i]]) begin
                timer_next[i] = tsat[i][TIMER_BITS-1:0];
                if (tsat[i] >= delay_ext) begin
                    repeat_next[i] = 1'b1;
                    timer_next[i]  = (tsat[i] > rate_ext)
                                   ? TIMER_BITS'(tsat[i] - rate_ext) : '0;
                end
            end
        end
    end

    // carried state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mask_reg <= '0;
            for (int i = 0; i < NUM_DIRS; i++) begin
                timer_reg[i] <= '0;
            end
        end else if (advance) begin
            prev_mask_reg <= held_next;
            for (int i = 0; i < NUM_DIRS; i++) begin
                timer_reg[i] <= timer_next[i];
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_reg     <= held_next;
            pressed_reg  <= pressed_next;
            released_reg <= released_next;
            repeat_reg   <= repeat_next;
            axis_x_reg   <= axis_x_next;
            axis_y_reg   <= axis_y_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, axis_y_reg, axis_x_reg, repeat_reg,
                       released_reg, pressed_reg, held_reg};

    // a repeat only fires on a held direction
    a_repeat_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((repeat_reg[0] == 1'b0 || held_reg[DIR_UP_BIT])
                      && (repeat_reg[1] == 1'b0 || held_reg[DIR_DOWN_BIT])
                      && (repeat_reg[2] == 1'b0 || held_reg[DIR_LEFT_BIT])
                      && (repeat_reg[3] == 1'b0 || held_reg[DIR_RIGHT_BIT])))
        else $error("repeat on a direction that is not held");

    // edges agree with the held mask
    a_edges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((pressed_reg & ~held_reg) == '0 && (released_reg & held_reg) == '0))
        else $error("press or release edge inconsistent with held mask");

    // carried state moves only with an item
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(prev_mask_reg))
        else $error("previous mask changed without an item");

    // a new result only appears when the input register held an item
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && !in_valid_reg) |=> !m_valid_reg)
        else $error("result appeared without an item");

endmodule
